// File: hw/rtl/tpts_pkg.sv
`default_nettype none
package tpts_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    KIND_ADD        = 3'd0,
    KIND_POP        = 3'd1,
    KIND_CANCEL_ID  = 3'd2,
    KIND_CANCEL_RCP = 3'd3,
    KIND_CANCEL_ALL = 3'd4
  } kind_t;

  typedef struct packed {
    logic [47:0] time_us;
    logic [19:0] dur;
    logic [7:0]  prio;
    logic [7:0]  recip;
    logic [31:0] rep;
    logic [31:0] timeout;
    logic        expect_rsp;
    logic [31:0] ident;
  } slot_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  priority_req;
    logic [47:0] start_time_us;
    logic [19:0] duration_us;
    logic [31:0] repeat_us;
    logic [7:0]  recipient;
    logic        expect_response;
    logic [31:0] read_timeout_us;
    logic [47:0] now_us;
    logic [31:0] target_id;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] entry_id;
    logic [7:0]  out_priority;
    logic [7:0]  out_recipient;
    logic        out_expect_response;
    logic [31:0] out_read_timeout_us;
    logic [31:0] out_repeat_us;
    logic [47:0] next_time_us;
    logic [4:0]  removed_count;
    logic        overflow;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WAIT,
    ST_SHIFT_WR,
    ST_WRITE_NEW,
    ST_DIV,
    ST_DIV_FIX,
    ST_MUL,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/tpts_if.sv
`default_nettype none
interface tpts_req_if;
  logic              valid;
  logic              ready;
  tpts_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpts_rsp_if;
  logic              valid;
  logic              ready;
  tpts_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tpts_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, 48 by 32 bits
module tpts_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [47:0]      quotient,
  output logic             rem_nonzero
);
  logic [47:0] quo;
  logic [32:0] rem;
  logic [5:0]  step;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem[31:0], quo[47]};
    trial   = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == 6'd47);
      if (start) begin
        busy <= 1'b1;
        step <= 6'd0;
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        // keep the trial remainder when it did not borrow
        rem  <= trial[32] ? shifted : trial;
        quo  <= {quo[46:0], ~trial[32]};
        step <= step + 6'd1;
        busy <= (step != 6'd47);
      end
    end
  end

  assign quotient    = quo;
  assign rem_nonzero = (rem != '0);
endmodule
`default_nettype wire

// File: hw/rtl/timed_priority_tx_scheduler_top.sv
`default_nettype none
// Timed priority transmission scheduler.
// req channel: one item per operation (add, pop, cancel by id, cancel by
// recipient, cancel all); rsp channel: exactly one result item per request.
// The 16-entry table lives in a memory with one registered read port; a
// sequencer compares one entry at a time, reading it in ST_RD and checking
// it in ST_CHECK, and moves entries one at a time through ST_SHIFT_RD,
// ST_SHIFT_WAIT and ST_SHIFT_WR when inserting or removing.
// From decode, cancel all, an add to a full table, a pop or cancel of an
// empty table and unused kinds go straight to the result state; a pop of a
// repeating head runs a divide and a shift-add multiply before re-inserting.
// One item at a time; req ready is high only in the idle state, so no new
// request is taken until the last result has been loaded for output.
// Reset clears the entry count and the id counter; the table memory is not
// cleared since only counted entries are ever read.
// When the receiver stalls the result waits in the output register; the
// next item is still taken and its result holds until the register drains.
module timed_priority_tx_scheduler_top (
  input wire logic clk,
  input wire logic rst,
  tpts_req_if.sink   req,
  tpts_rsp_if.source rsp
);
  localparam int unsigned IW = tpts_pkg::IdxW;
  localparam int unsigned CW = tpts_pkg::CntW;

  // table memory
  tpts_pkg::slot_t mem [tpts_pkg::TableDepth];
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  logic            wr_en;
  tpts_pkg::slot_t wr_data;
  tpts_pkg::slot_t rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  tpts_pkg::state_t state, state_next;
  tpts_pkg::req_t   rq;
  tpts_pkg::rsp_t   res;
  tpts_pkg::slot_t  nslot;
  tpts_pkg::slot_t  head;
  logic [CW-1:0]    used;
  logic [31:0]      next_ident;
  logic [CW-1:0]    idx;      // scan index
  logic [CW-1:0]    sidx;     // shift index
  logic             shift_up; // open gap (insert) vs close gap (remove)
  logic [CW-1:0]    ins_pos;
  logic [4:0]       cnt;
  logic             repop;    // add phase of a repeating pop
  logic [47:0]      hstart;
  logic             out_valid;
  tpts_pkg::rsp_t   out_data;
  tpts_pkg::rsp_t   dec_res;
  tpts_pkg::rsp_t   found_rsp;
  tpts_pkg::slot_t  new_slot;
  tpts_pkg::slot_t  adv_slot;
  logic             is_add;
  logic             scan_last;
  logic             key_hit;
  logic             out_load;

  // divider and multiplier for the repeat advance
  logic        div_start, div_done, div_rnz;
  logic [47:0] div_q;
  logic [47:0] mult_n;
  logic [47:0] mul_acc;
  logic [31:0] mul_b;
  logic [5:0]  mul_step;

  tpts_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(rq.now_us - head.time_us), .divisor(head.rep),
    .done(div_done), .quotient(div_q), .rem_nonzero(div_rnz)
  );

  // comparisons against the entry just read
  logic [48:0] n_fin, e_fin;
  logic        add_hit, pop_hit, cid_hit, crc_hit;
  always_comb begin
    n_fin   = {1'b0, nslot.time_us} + {29'b0, nslot.dur};
    e_fin   = {1'b0, rd_data.time_us} + {29'b0, rd_data.dur};
    add_hit = (nslot.time_us < rd_data.time_us)
              ? ((n_fin < {1'b0, rd_data.time_us}) || (nslot.prio <= rd_data.prio))
              : (({1'b0, nslot.time_us} < e_fin) && (nslot.prio < rd_data.prio));
    pop_hit = (rq.now_us >= rd_data.time_us) && (e_fin < {1'b0, hstart});
    cid_hit = (rd_data.ident == rq.target_id);
    crc_hit = (rd_data.recip == rq.recipient);
    key_hit = (rq.kind == tpts_pkg::KIND_CANCEL_ID) ? cid_hit : crc_hit;
    is_add    = (rq.kind == tpts_pkg::KIND_ADD) || repop;
    scan_last = ((idx + CW'(1)) >= used);
  end

  // new entry, advanced head, and result words
  always_comb begin
    new_slot            = '0;
    new_slot.time_us    = rq.start_time_us;
    new_slot.dur        = rq.duration_us;
    new_slot.prio       = rq.priority_req;
    new_slot.recip      = rq.recipient;
    new_slot.rep        = rq.repeat_us;
    new_slot.timeout    = rq.read_timeout_us;
    new_slot.expect_rsp = rq.expect_response;
    new_slot.ident      = next_ident;

    adv_slot         = head;
    adv_slot.time_us = mul_acc;

    dec_res = '0;
    if (rq.kind == tpts_pkg::KIND_ADD) begin
      dec_res.entry_id = next_ident;
      dec_res.overflow = (used == CW'(tpts_pkg::TableDepth));
    end
    if (rq.kind == tpts_pkg::KIND_CANCEL_ALL) dec_res.removed_count = 5'(used);

    found_rsp                     = '0;
    found_rsp.found               = 1'b1;
    found_rsp.entry_id            = head.ident;
    found_rsp.out_priority        = head.prio;
    found_rsp.out_recipient       = head.recip;
    found_rsp.out_expect_response = head.expect_rsp;
    found_rsp.out_read_timeout_us = head.timeout;
    found_rsp.out_repeat_us       = head.rep;
    found_rsp.next_time_us        = head.time_us;
  end

  // outputs
  always_comb begin
    req.ready = (state == tpts_pkg::ST_IDLE);
    rsp.valid = out_valid;
    rsp.data  = out_data;
    out_load  = (state == tpts_pkg::ST_RESULT) && (!out_valid || rsp.ready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tpts_pkg::ST_IDLE: if (req.valid && req.ready) state_next = tpts_pkg::ST_DECODE;
      tpts_pkg::ST_DECODE: begin
        unique case (rq.kind)
          tpts_pkg::KIND_ADD: begin
            if (used == CW'(tpts_pkg::TableDepth)) state_next = tpts_pkg::ST_RESULT;
            else if (used == '0) state_next = tpts_pkg::ST_WRITE_NEW;
            else state_next = tpts_pkg::ST_RD;
          end
          tpts_pkg::KIND_POP, tpts_pkg::KIND_CANCEL_ID, tpts_pkg::KIND_CANCEL_RCP:
            state_next = (used == '0) ? tpts_pkg::ST_RESULT : tpts_pkg::ST_RD;
          default: state_next = tpts_pkg::ST_RESULT;
        endcase
      end
      tpts_pkg::ST_RD: state_next = tpts_pkg::ST_CHECK;
      tpts_pkg::ST_CHECK: begin
        if (is_add) begin
          if (add_hit) state_next = tpts_pkg::ST_SHIFT_RD;
          else if (scan_last) state_next = tpts_pkg::ST_WRITE_NEW;
          else state_next = tpts_pkg::ST_RD;
        end else if (rq.kind == tpts_pkg::KIND_POP) begin
          if (idx == '0 && rq.now_us >= rd_data.time_us) state_next = tpts_pkg::ST_SHIFT_RD;
          else if (idx != '0 && pop_hit) state_next = tpts_pkg::ST_SHIFT_RD;
          else if (scan_last) state_next = tpts_pkg::ST_RESULT;
          else state_next = tpts_pkg::ST_RD;
        end else begin
          if (key_hit) state_next = tpts_pkg::ST_SHIFT_RD;
          else if (scan_last) state_next = tpts_pkg::ST_RESULT;
          else state_next = tpts_pkg::ST_RD;
        end
      end
      tpts_pkg::ST_SHIFT_RD: begin
        if (shift_up) begin
          state_next = (sidx == ins_pos) ? tpts_pkg::ST_WRITE_NEW : tpts_pkg::ST_SHIFT_WAIT;
        end else if ((sidx + CW'(1)) >= used) begin
          // removal finished; decide what follows
          if (rq.kind == tpts_pkg::KIND_POP) begin
            state_next = (idx == '0 && head.rep != 32'd0) ? tpts_pkg::ST_DIV
                                                          : tpts_pkg::ST_RESULT;
          end else begin
            state_next = scan_last ? tpts_pkg::ST_RESULT : tpts_pkg::ST_RD;
          end
        end else begin
          state_next = tpts_pkg::ST_SHIFT_WAIT;
        end
      end
      tpts_pkg::ST_SHIFT_WAIT: state_next = tpts_pkg::ST_SHIFT_WR;
      tpts_pkg::ST_SHIFT_WR: state_next = tpts_pkg::ST_SHIFT_RD;
      tpts_pkg::ST_WRITE_NEW: state_next = tpts_pkg::ST_RESULT;
      tpts_pkg::ST_DIV: if (div_done) state_next = tpts_pkg::ST_DIV_FIX;
      tpts_pkg::ST_DIV_FIX: state_next = tpts_pkg::ST_MUL;
      tpts_pkg::ST_MUL: begin
        if (mul_step == 6'd32)
          state_next = (used == '0) ? tpts_pkg::ST_WRITE_NEW : tpts_pkg::ST_RD;
      end
      tpts_pkg::ST_RESULT: if (out_load) state_next = tpts_pkg::ST_IDLE;
      default: state_next = tpts_pkg::ST_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tpts_pkg::ST_IDLE;
      used       <= '0;
      next_ident <= '0;
      out_valid  <= 1'b0;
      div_start  <= 1'b0;
      wr_en      <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= (state_next == tpts_pkg::ST_DIV) && (state != tpts_pkg::ST_DIV);
      wr_en     <= (state == tpts_pkg::ST_SHIFT_WR) || (state == tpts_pkg::ST_WRITE_NEW);
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      unique case (state)
        tpts_pkg::ST_IDLE: begin
          if (req.valid && req.ready) rq <= req.data;
        end
        tpts_pkg::ST_DECODE: begin
          res     <= dec_res;
          idx     <= '0;
          cnt     <= '0;
          repop   <= 1'b0;
          rd_addr <= '0;
          ins_pos <= '0;
          nslot   <= new_slot;
          if (rq.kind == tpts_pkg::KIND_ADD) next_ident <= next_ident + 32'd1;
          if (rq.kind == tpts_pkg::KIND_CANCEL_ALL) used <= '0;
        end
        tpts_pkg::ST_RD, tpts_pkg::ST_SHIFT_WAIT, tpts_pkg::ST_DIV: ;
        tpts_pkg::ST_CHECK: begin
          if (is_add) begin
            if (add_hit) begin
              ins_pos  <= idx;
              sidx     <= used;
              shift_up <= 1'b1;
            end else if (scan_last) begin
              ins_pos <= used;
            end else begin
              idx     <= idx + CW'(1);
              rd_addr <= IW'(idx + CW'(1));
            end
          end else if (rq.kind == tpts_pkg::KIND_POP) begin
            if (idx == '0) begin
              hstart <= rd_data.time_us;
              head   <= rd_data;
              if (rq.now_us >= rd_data.time_us) begin
                sidx      <= '0;
                shift_up  <= 1'b0;
                res.found <= 1'b1;
              end else if (!scan_last) begin
                idx     <= CW'(1);
                rd_addr <= IW'(1);
              end
            end else if (pop_hit) begin
              head      <= rd_data;
              sidx      <= idx;
              shift_up  <= 1'b0;
              res.found <= 1'b1;
            end else if (!scan_last) begin
              idx     <= idx + CW'(1);
              rd_addr <= IW'(idx + CW'(1));
            end
          end else begin
            // cancel by id or recipient
            if (key_hit) begin
              cnt      <= cnt + 5'd1;
              sidx     <= idx;
              shift_up <= 1'b0;
            end else if (scan_last) begin
              res.removed_count <= cnt;
            end else begin
              idx     <= idx + CW'(1);
              rd_addr <= IW'(idx + CW'(1));
            end
          end
        end
        tpts_pkg::ST_SHIFT_RD: begin
          // insert: move sidx-1 to sidx, down to ins_pos; remove: sidx+1 to sidx
          if (shift_up) begin
            if (sidx != ins_pos) rd_addr <= IW'(sidx - CW'(1));
          end else if ((sidx + CW'(1)) >= used) begin
            used <= used - CW'(1);
            if (rq.kind != tpts_pkg::KIND_POP) begin
              if (scan_last) res.removed_count <= cnt;
              else rd_addr <= IW'(idx);
            end
          end else begin
            rd_addr <= IW'(sidx + CW'(1));
          end
        end
        tpts_pkg::ST_SHIFT_WR: begin
          wr_addr <= IW'(sidx);
          wr_data <= rd_data;
          sidx    <= shift_up ? sidx - CW'(1) : sidx + CW'(1);
        end
        tpts_pkg::ST_WRITE_NEW: begin
          wr_addr <= IW'(ins_pos);
          wr_data <= nslot;
          used    <= used + CW'(1);
        end
        tpts_pkg::ST_DIV_FIX: begin
          mult_n <= ((div_q + {47'b0, div_rnz}) == '0) ? 48'd1
                    : div_q + {47'b0, div_rnz};
          mul_acc  <= head.time_us;
          mul_b    <= head.rep;
          mul_step <= '0;
        end
        tpts_pkg::ST_MUL: begin
          // shift-add: acc += n * rep, one rep bit per cycle, mod 2^48
          if (mul_b[0]) mul_acc <= mul_acc + mult_n;
          mult_n   <= {mult_n[46:0], 1'b0};
          mul_b    <= {1'b0, mul_b[31:1]};
          mul_step <= mul_step + 6'd1;
          if (mul_step == 6'd32) begin
            head    <= adv_slot;
            nslot   <= adv_slot;
            repop   <= 1'b1;
            idx     <= '0;
            rd_addr <= '0;
            ins_pos <= '0;
          end
        end
        tpts_pkg::ST_RESULT: begin
          if (out_load) out_data <= res.found ? found_rsp : res;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
